// File: hdl/bmrd_pkg.sv
// Shared types, constants and address helpers for the key-matrix release debouncer.
`timescale 1ns / 1ps

package bmrd_pkg;

    localparam int ROWS    = 8;
    localparam int COLS    = 8;
    localparam int ROW_W   = 3;
    localparam int COL_W   = 3;
    localparam int CNT_W   = 8;
    localparam int ENTRIES = ROWS * COLS;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [CNT_W-1:0] RELEASE_COUNT_RESET = CNT_W'(20);

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic             raw_now;
        logic             raw_before;
    } in_item_t;

    typedef struct packed {
        logic             event_res;
        logic [ROW_W-1:0] event_row;
        logic [COL_W-1:0] event_column;
        logic             debounced_level;
    } out_item_t;

    // One button's stored state
    typedef struct packed {
        logic             level;
        logic [CNT_W-1:0] count;
    } entry_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } mem_wr_t;

    function automatic logic btn_in_range(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
        return (int'(row) < ROWS) && (int'(col) < COLS);
    endfunction

    function automatic logic [ADDR_W-1:0] btn_addr(logic [ROW_W-1:0] row,
                                                   logic [COL_W-1:0] col);
        return ADDR_W'(int'(row) * COLS + int'(col));
    endfunction

endpackage

// File: hdl/bmrd_state_mem.sv
// Per-button state memory: registered read, one write port, reset-cleared valid bits.
`timescale 1ns / 1ps

module bmrd_state_mem (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [bmrd_pkg::ADDR_W-1:0]  rd_addr,
    output bmrd_pkg::entry_t             rd_data,
    input  bmrd_pkg::mem_wr_t            wr
);

    bmrd_pkg::entry_t                   mem [bmrd_pkg::ENTRIES];
    logic [bmrd_pkg::ENTRIES-1:0]       valid_reg;
    bmrd_pkg::entry_t                   rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // never-written entries read as the reset value
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/bmrd_update.sv
// Debounce decision for one button: new level, counter and event flag.
`timescale 1ns / 1ps

module bmrd_update (
    input  bmrd_pkg::in_item_t               item,
    input  logic                             in_range,
    input  bmrd_pkg::entry_t                 cur,
    input  logic [bmrd_pkg::CNT_W-1:0]       release_count,
    output bmrd_pkg::entry_t                 nxt,
    output logic                             event_res,
    output logic                             level
);

    logic changed;
    logic differs;

    always_comb
    begin
        changed   = item.raw_now != item.raw_before;
        differs   = item.raw_now != cur.level;
        nxt       = cur;
        event_res = 1'b0;
        if (changed && differs)
        begin
            if (item.raw_now)
            begin
                // press taken at once
                nxt.level = 1'b1;
                event_res = 1'b1;
            end
            else
            begin
                nxt.count = release_count;
            end
        end
        else if (!changed && differs && (cur.count != '0))
        begin
            nxt.count = cur.count - bmrd_pkg::CNT_W'(1);
            if (cur.count == bmrd_pkg::CNT_W'(1))
            begin
                nxt.level = item.raw_now;
                event_res = 1'b1;
            end
        end
        if (!in_range)
        begin
            event_res = 1'b0;
        end
        level = in_range ? nxt.level : 1'b0;
    end

endmodule

// File: hdl/button_matrix_release_debouncer_top.sv
// Top level of the key-matrix release debouncer: read stage, update stage, output register.
`timescale 1ns / 1ps
// Throughput: one transfer per cycle; input stalls only when both stages hold a result
// and out_ready is low. Memory has separate read and write ports.
// Path: the accepted item is registered with its state read, then the result in the output register.
// Memory read is issued on acceptance; update and write-back happen as the result moves
// to the output register; a bypass register covers back-to-back checks of one button.
// Reset: all buttons released, counters zero (per-entry valid bits), release_count = 20.

module button_matrix_release_debouncer_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  bmrd_pkg::in_item_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output bmrd_pkg::out_item_t   out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [7:0]            cfg_data
);

    // configuration register
    logic [bmrd_pkg::CNT_W-1:0]   release_count_reg;

    // update stage: item whose state read is in flight
    logic                         s1_valid_reg;
    bmrd_pkg::in_item_t           s1_item_reg;
    logic [bmrd_pkg::ADDR_W-1:0]  s1_addr_reg;
    logic                         s1_in_range_reg;

    // bypass of the most recent write-back
    logic                         fwd_valid_reg;
    logic [bmrd_pkg::ADDR_W-1:0]  fwd_addr_reg;
    bmrd_pkg::entry_t             fwd_data_reg;

    // output register
    logic                         out_valid_reg;
    bmrd_pkg::out_item_t          out_data_reg;

    logic                         in_xfer;
    logic                         s1_adv;
    logic [bmrd_pkg::ADDR_W-1:0]  in_addr;
    bmrd_pkg::entry_t             rd_data;
    bmrd_pkg::entry_t             cur_entry;
    bmrd_pkg::entry_t             nxt_entry;
    logic                         upd_event;
    logic                         upd_level;
    bmrd_pkg::mem_wr_t            wr;

    assign cfg_ready = 1'b1;

    // stage moves on when the output register is free or being drained
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_xfer  = in_valid && in_ready;
    assign in_addr  = bmrd_pkg::btn_addr(in_data.row, in_data.column);

    bmrd_state_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_xfer),
        .rd_addr (in_addr),
        .rd_data (rd_data),
        .wr      (wr)
    );

    // the read missed a write made on the same edge; older ones are already in memory
    assign cur_entry = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg
                                                                         : rd_data;

    bmrd_update u_update (
        .item          (s1_item_reg),
        .in_range      (s1_in_range_reg),
        .cur           (cur_entry),
        .release_count (release_count_reg),
        .nxt           (nxt_entry),
        .event_res     (upd_event),
        .level         (upd_level)
    );

    always_comb
    begin
        wr.en   = s1_adv && s1_in_range_reg;
        wr.addr = s1_addr_reg;
        wr.data = nxt_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            release_count_reg <= bmrd_pkg::RELEASE_COUNT_RESET;
            s1_valid_reg      <= 1'b0;
            fwd_valid_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                release_count_reg <= cfg_data;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (wr.en)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_item_reg     <= in_data;
            s1_addr_reg     <= in_addr;
            s1_in_range_reg <= bmrd_pkg::btn_in_range(in_data.row, in_data.column);
        end
        if (wr.en)
        begin
            fwd_addr_reg <= wr.addr;
            fwd_data_reg <= wr.data;
        end
        if (s1_adv)
        begin
            out_data_reg.event_res       <= upd_event;
            out_data_reg.event_row       <= s1_item_reg.row;
            out_data_reg.event_column    <= s1_item_reg.column;
            out_data_reg.debounced_level <= upd_level;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: hdl/bmrd_checker.sv
// Port-level checks for the key-matrix release debouncer, bound to the top level.
`timescale 1ns / 1ps

module bmrd_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  bmrd_pkg::out_item_t   out_data
);

    // transfers taken in but not yet delivered
    logic [2:0] pending_reg;
    logic [2:0] pending_next;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_valid && in_ready)
        begin
            pending_next = pending_next + 3'd1;
        end
        if (out_valid && out_ready)
        begin
            pending_next = pending_next - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result without a pending input");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd2)
        else $error("more items in flight than stages");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

endmodule

bind button_matrix_release_debouncer_top bmrd_checker u_bmrd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// File: tb/bmrd_debounce_checker.sv
// Checker for the key-matrix release debouncer: predicts each check and compares the results.
`timescale 1ns / 1ps

module bmrd_debounce_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  bmrd_pkg::in_item_t    in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  bmrd_pkg::out_item_t   out_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [7:0]            cfg_data,
    output int                    errors,
    output int                    pending,
    output int                    compared
);

    localparam int BUTTONS = bmrd_pkg::ROWS * bmrd_pkg::COLS;

    // Own copy of the debounced map, the release counters and the register
    logic                         level_map  [BUTTONS];
    logic [bmrd_pkg::CNT_W-1:0]   hold_count [BUTTONS];
    logic [bmrd_pkg::CNT_W-1:0]   release_len;

    bmrd_pkg::out_item_t          predicted_reports [$];
    int                           fail_tally;
    int                           match_tally;

    // Debounce one button check, updating the local state
    function automatic bmrd_pkg::out_item_t debounce_check(bmrd_pkg::in_item_t item);
        bmrd_pkg::out_item_t res;
        int                  idx;
        logic                held;
        res.event_res       = 1'b0;
        res.event_row       = item.row;
        res.event_column    = item.column;
        res.debounced_level = 1'b0;
        if (int'(item.row) < bmrd_pkg::ROWS && int'(item.column) < bmrd_pkg::COLS)
        begin
            idx  = int'(item.row) * bmrd_pkg::COLS + int'(item.column);
            held = level_map[idx];
            if (item.raw_now != item.raw_before && item.raw_now != held)
            begin
                if (item.raw_now)
                begin
                    res.event_res  = 1'b1;
                    level_map[idx] = 1'b1;
                end
                else
                begin
                    hold_count[idx] = release_len;
                end
            end
            else if (item.raw_now == item.raw_before && item.raw_now != held)
            begin
                if (hold_count[idx] != '0)
                begin
                    hold_count[idx] = hold_count[idx] - bmrd_pkg::CNT_W'(1);
                    if (hold_count[idx] == '0)
                    begin
                        res.event_res  = 1'b1;
                        level_map[idx] = item.raw_now;
                    end
                end
            end
            res.debounced_level = level_map[idx];
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        bmrd_pkg::out_item_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < BUTTONS; i++)
            begin
                level_map[i]  = 1'b0;
                hold_count[i] = '0;
            end
            release_len = bmrd_pkg::RELEASE_COUNT_RESET;
            predicted_reports.delete();
            fail_tally  = 0;
            match_tally = 0;
            errors   <= 0;
            pending  <= 0;
            compared <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                release_len = cfg_data;
            if (in_valid && in_ready)
                predicted_reports.push_back(debounce_check(in_data));
            if (out_valid && out_ready)
            begin
                if (predicted_reports.size() == 0)
                begin
                    $error("result transfer with nothing predicted: %p", out_data);
                    fail_tally++;
                end
                else
                begin
                    want = predicted_reports.pop_front();
                    match_tally++;
                    if (out_data.event_res !== want.event_res)
                    begin
                        $error("event_res: expected %0d, actual %0d",
                               want.event_res, out_data.event_res);
                        fail_tally++;
                    end
                    if (out_data.event_row !== want.event_row)
                    begin
                        $error("event_row: expected %0d, actual %0d",
                               want.event_row, out_data.event_row);
                        fail_tally++;
                    end
                    if (out_data.event_column !== want.event_column)
                    begin
                        $error("event_column: expected %0d, actual %0d",
                               want.event_column, out_data.event_column);
                        fail_tally++;
                    end
                    if (out_data.debounced_level !== want.debounced_level)
                    begin
                        $error("debounced_level: expected %0d, actual %0d",
                               want.debounced_level, out_data.debounced_level);
                        fail_tally++;
                    end
                end
            end
            // Published after the edge so the stimulus side never races the update
            errors   <= fail_tally;
            pending  <= predicted_reports.size();
            compared <= match_tally;
        end
    end

endmodule

// File: tb/button_matrix_release_debouncer_top_test.sv
// Test top for the key-matrix release debouncer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module button_matrix_release_debouncer_top_test;

    // Cycles with no transfer on any channel before the run is called dead
    localparam int WATCHDOG_LIMIT = 2000;
    // Settling margin once the output register has delivered the last result
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASES         = 7;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    bmrd_pkg::in_item_t    in_data;
    logic                  out_valid;
    logic                  out_ready;
    bmrd_pkg::out_item_t   out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [7:0]            cfg_data;

    int          fail_count;
    int          pending;
    int          results_seen;

    bit          calm;              // no idling on either side when set
    int          checks_sent;
    int          settings_used;
    int          quiet_cycles = 0;

    button_matrix_release_debouncer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    bmrd_debounce_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (fail_count),
        .pending   (pending),
        .compared  (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: any transfer on any channel counts as progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: stalls start at random and last a random length, none once calm is set.
    // Exactly one assignment to out_ready per edge.
    initial
    begin : result_sink
        int stall_left;
        out_ready  = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 6);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // One button check. A sender gap, when taken, lowers valid first; otherwise valid
    // stays high from the previous transfer and only the payload moves on.
    task automatic check_button(input int r, input int c, input bit now, input bit prev);
        bmrd_pkg::in_item_t item;
        item.row        = bmrd_pkg::ROW_W'(r);
        item.column     = bmrd_pkg::COL_W'(c);
        item.raw_now    = now;
        item.raw_before = prev;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        checks_sent++;
    endtask

    task automatic noise_check;
        check_button(int'($urandom_range(0, bmrd_pkg::ROWS - 1)),
                     int'($urandom_range(0, bmrd_pkg::COLS - 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // Hold the input side until every predicted result has been seen, then let
    // the pipeline settle. The first edge lets the checker's count catch up.
    task automatic drain_results;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write, only ever with the block idle
    task automatic write_release_count(input int value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= 8'(value);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Press, optional held scans, release, then a run of stable released scans
    // sized around the release count so acceptance lands just short, on, or past it.
    // Rare bounces and stray checks, scaled down for long counts.
    task automatic release_episode(input int r, input int c, input int len);
        int run;
        check_button(r, c, 1'b1, 1'b0);
        repeat ($urandom_range(0, 2)) check_button(r, c, 1'b1, 1'b1);
        check_button(r, c, 1'b0, 1'b1);
        if (len == 0)
            run = $urandom_range(1, 4);
        else
        begin
            case ($urandom_range(0, 4))
                0:       run = len - 1;
                1:       run = len + $urandom_range(1, 3);
                default: run = len;
            endcase
        end
        for (int k = 0; k < run; k++)
        begin
            if ($urandom_range(0, 4 * len + 16) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       check_button(r, c, 1'b1, 1'b0);   // bounce back up
                    1:       check_button(r, c, 1'b0, 1'b1);   // second release edge reloads
                    default: noise_check();
                endcase
            end
            else
                check_button(r, c, 1'b0, 1'b0);
        end
    endtask

    initial
    begin : stimulus
        int phase_len   [PHASES];
        int phase_items [PHASES];
        int pool_row    [4];
        int pool_col    [4];
        int target;
        int pick;

        in_valid      = 1'b0;
        in_data       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        rst_n         = 1'b0;
        calm          = 1'b0;
        checks_sent   = 0;
        settings_used = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset count of 20 first
        check_button(0, 0, 1'b1, 1'b0);     // new press: accepted at once
        check_button(0, 0, 1'b1, 1'b0);     // press edge on a pressed button
        check_button(0, 0, 1'b1, 1'b1);
        check_button(7, 7, 1'b1, 1'b1);     // stable press with idle counter
        check_button(7, 7, 1'b0, 1'b1);     // release edge on a released button
        check_button(0, 0, 1'b0, 1'b1);     // release loads 20
        check_button(0, 0, 1'b0, 1'b0);
        check_button(0, 0, 1'b0, 1'b0);

        write_release_count(1);
        check_button(0, 0, 1'b0, 1'b0);     // old load keeps counting
        check_button(7, 7, 1'b1, 1'b0);
        check_button(7, 7, 1'b0, 1'b1);
        check_button(7, 7, 1'b0, 1'b0);     // accepted after one stable check
        check_button(7, 7, 1'b0, 1'b0);     // counter stays at zero afterwards
        check_button(3, 5, 1'b1, 1'b0);
        check_button(3, 5, 1'b0, 1'b1);
        check_button(3, 5, 1'b1, 1'b1);     // bounce back, no count
        check_button(3, 5, 1'b0, 1'b0);

        write_release_count(0);             // loaded zero never counts down
        check_button(2, 6, 1'b1, 1'b0);
        check_button(2, 6, 1'b0, 1'b1);
        check_button(2, 6, 1'b0, 1'b0);
        check_button(2, 6, 1'b0, 1'b0);

        write_release_count(255);
        check_button(5, 2, 1'b1, 1'b0);
        check_button(5, 2, 1'b0, 1'b1);
        check_button(5, 2, 1'b0, 1'b0);

        // Random part: a handful of settings, mostly release episodes on a small pool
        // of buttons so counters get deep, the rest stray checks anywhere
        phase_len   = '{3, 1, 255, 0, 2, 0, 20};
        phase_len[5] = $urandom_range(4, 12);
        phase_items = '{250, 200, 250, 150, 200, 200, 150};

        for (int p = 0; p < PHASES; p++)
        begin
            write_release_count(phase_len[p]);
            if (p == PHASES - 1)
                calm = 1'b1;
            for (int b = 0; b < 4; b++)
            begin
                pool_row[b] = $urandom_range(0, bmrd_pkg::ROWS - 1);
                pool_col[b] = $urandom_range(0, bmrd_pkg::COLS - 1);
            end
            target = checks_sent + phase_items[p];
            while (checks_sent < target)
            begin
                if ($urandom_range(0, 5) == 0)
                    noise_check();
                else
                begin
                    pick = $urandom_range(0, 3);
                    release_episode(pool_row[pick], pool_col[pick], phase_len[p]);
                end
            end
        end

        // Everything sent: wait for the tail, then idle to catch strays
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (2 * SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d button checks and compared %0d results over %0d release-count writes,",
                 checks_sent, results_seen, settings_used);
        $display("counts 0, 1, 255 and the reset value among them, with and without idling.");
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
